// ----- design/ofau_pkg.sv -----
// Shared types and constants for the operand fetch addressing unit.
// Holds addressing mode codes, result kinds, fetch phases and the item,
// state and result structs. No dependencies.
package ofau_pkg;

    localparam int unsigned MODE_W = 5;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned COUNT_W = 2;

    localparam logic [WORD_W-1:0] HIGH_PAGE = 16'hFF00;

    localparam logic [MODE_W-1:0] MODE_IMPL       = 5'd0;
    localparam logic [MODE_W-1:0] MODE_REG        = 5'd1;
    localparam logic [MODE_W-1:0] MODE_REG_REG    = 5'd2;
    localparam logic [MODE_W-1:0] MODE_REG_D8     = 5'd3;
    localparam logic [MODE_W-1:0] MODE_REG_D16    = 5'd4;
    localparam logic [MODE_W-1:0] MODE_D16        = 5'd5;
    localparam logic [MODE_W-1:0] MODE_MEMREG_REG = 5'd6;
    localparam logic [MODE_W-1:0] MODE_REG_MEMREG = 5'd7;
    localparam logic [MODE_W-1:0] MODE_REG_HLI    = 5'd8;
    localparam logic [MODE_W-1:0] MODE_REG_HLD    = 5'd9;
    localparam logic [MODE_W-1:0] MODE_HLI_REG    = 5'd10;
    localparam logic [MODE_W-1:0] MODE_HLD_REG    = 5'd11;
    localparam logic [MODE_W-1:0] MODE_REG_A8     = 5'd12;
    localparam logic [MODE_W-1:0] MODE_A8_REG     = 5'd13;
    localparam logic [MODE_W-1:0] MODE_HL_SPR     = 5'd14;
    localparam logic [MODE_W-1:0] MODE_D8         = 5'd15;
    localparam logic [MODE_W-1:0] MODE_A16_REG    = 5'd16;
    localparam logic [MODE_W-1:0] MODE_D16_REG    = 5'd17;
    localparam logic [MODE_W-1:0] MODE_MEMREG_D8  = 5'd18;
    localparam logic [MODE_W-1:0] MODE_MEMREG     = 5'd19;
    localparam logic [MODE_W-1:0] MODE_REG_A16    = 5'd20;

    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SECOND = 2'd2;
    localparam logic [PHASE_W-1:0] PH_TARGET = 2'd3;

    typedef struct packed {
        logic              is_data;
        logic [MODE_W-1:0] addr_mode;
        logic [WORD_W-1:0] reg1_value;
        logic [WORD_W-1:0] reg2_value;
        logic              reg1_is_c;
        logic              reg2_is_c;
        logic [WORD_W-1:0] hl_value;
        logic [WORD_W-1:0] pc_value;
        logic [BYTE_W-1:0] read_data;
    } item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [MODE_W-1:0]  latched_mode;
        logic [BYTE_W-1:0]  low_byte;
        logic [WORD_W-1:0]  pc;
        logic [WORD_W-1:0]  held_operand;
        logic [WORD_W-1:0]  fetched;
        logic [WORD_W-1:0]  dest;
        logic               dest_flag;
        logic [COUNT_W-1:0] read_count;
        logic [WORD_W-1:0]  hl;
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [WORD_W-1:0]  bus_address;
        logic [WORD_W-1:0]  fetched_data;
        logic [WORD_W-1:0]  dest_address;
        logic               dest_is_memory;
        logic [WORD_W-1:0]  new_pc;
        logic [WORD_W-1:0]  new_hl;
        logic               hl_written;
        logic [COUNT_W-1:0] bus_cycles;
    } result_t;

endpackage

// ----- design/ofau_step.sv -----
// Next-state and result logic for one transaction of the operand fetch unit.
// Depends on ofau_pkg for the item, state and result structs and all codes.
module ofau_step (
    input  ofau_pkg::item_t   item,
    input  ofau_pkg::state_t  st,
    output ofau_pkg::state_t  st_next,
    output ofau_pkg::result_t res
);
    import ofau_pkg::*;

    always_comb
    begin
        state_t             nxt;
        result_t            r;
        logic               do_done;
        logic               do_req;
        logic               do_err;
        logic [WORD_W-1:0]  req_addr;
        logic [PHASE_W-1:0] req_phase;
        logic [WORD_W-1:0]  d;
        logic [WORD_W-1:0]  w;
        logic [WORD_W-1:0]  r1_page;
        logic [WORD_W-1:0]  r2_page;

        nxt       = st;
        r         = '0;
        do_done   = 1'b0;
        do_req    = 1'b0;
        do_err    = 1'b0;
        req_addr  = '0;
        req_phase = PH_FIRST;
        d         = {{(WORD_W-BYTE_W){1'b0}}, item.read_data};
        w         = {item.read_data, st.low_byte};
        r1_page   = item.reg1_value | (item.reg1_is_c ? HIGH_PAGE : '0);
        r2_page   = item.reg2_value | (item.reg2_is_c ? HIGH_PAGE : '0);

        if (!item.is_data)
        begin
            if (item.addr_mode > MODE_REG_A16)
            begin
                do_err = 1'b1;
            end
            else
            begin
                nxt.latched_mode = item.addr_mode;
                nxt.pc           = item.pc_value;
                nxt.hl           = item.hl_value;
                nxt.dest         = '0;
                nxt.dest_flag    = 1'b0;
                nxt.read_count   = '0;
                nxt.low_byte     = '0;
                nxt.held_operand = (item.addr_mode == MODE_MEMREG_D8) ?
                                   item.reg1_value : item.reg2_value;
                case (item.addr_mode)
                    MODE_IMPL:
                    begin
                        do_done = 1'b1;
                    end
                    MODE_REG:
                    begin
                        nxt.fetched = item.reg1_value;
                        do_done     = 1'b1;
                    end
                    MODE_REG_REG:
                    begin
                        nxt.fetched = item.reg2_value;
                        do_done     = 1'b1;
                    end
                    MODE_MEMREG_REG:
                    begin
                        nxt.fetched   = item.reg2_value;
                        nxt.dest      = r1_page;
                        nxt.dest_flag = 1'b1;
                        do_done       = 1'b1;
                    end
                    MODE_REG_MEMREG:
                    begin
                        do_req   = 1'b1;
                        req_addr = r2_page;
                    end
                    MODE_REG_HLI, MODE_REG_HLD:
                    begin
                        do_req   = 1'b1;
                        req_addr = item.reg2_value;
                    end
                    MODE_HLI_REG, MODE_HLD_REG:
                    begin
                        nxt.fetched   = item.reg2_value;
                        nxt.dest      = item.reg1_value;
                        nxt.dest_flag = 1'b1;
                        nxt.hl        = (item.addr_mode == MODE_HLI_REG) ?
                                        item.hl_value + 1'b1 : item.hl_value - 1'b1;
                        do_done       = 1'b1;
                    end
                    MODE_MEMREG:
                    begin
                        nxt.dest      = item.reg1_value;
                        nxt.dest_flag = 1'b1;
                        do_req        = 1'b1;
                        req_addr      = item.reg1_value;
                    end
                    default:
                    begin
                        do_req   = 1'b1;
                        req_addr = item.pc_value;
                    end
                endcase
            end
        end
        else if (st.phase == PH_IDLE)
        begin
            do_err = 1'b1;
        end
        else
        begin
            nxt.read_count = st.read_count + 1'b1;
            case (st.latched_mode)
                MODE_REG_D8, MODE_REG_A8, MODE_HL_SPR, MODE_D8:
                begin
                    nxt.fetched = d;
                    nxt.pc      = st.pc + 1'b1;
                    do_done     = 1'b1;
                end
                MODE_REG_MEMREG, MODE_MEMREG:
                begin
                    nxt.fetched = d;
                    do_done     = 1'b1;
                end
                MODE_REG_HLI, MODE_REG_HLD:
                begin
                    nxt.fetched = d;
                    nxt.hl      = (st.latched_mode == MODE_REG_HLI) ?
                                  st.hl + 1'b1 : st.hl - 1'b1;
                    do_done     = 1'b1;
                end
                MODE_A8_REG:
                begin
                    nxt.dest      = d | HIGH_PAGE;
                    nxt.dest_flag = 1'b1;
                    nxt.pc        = st.pc + 1'b1;
                    do_done       = 1'b1;
                end
                MODE_MEMREG_D8:
                begin
                    nxt.fetched   = d;
                    nxt.pc        = st.pc + 1'b1;
                    nxt.dest      = st.held_operand;
                    nxt.dest_flag = 1'b1;
                    do_done       = 1'b1;
                end
                MODE_REG_D16, MODE_D16, MODE_A16_REG, MODE_D16_REG, MODE_REG_A16:
                begin
                    if (st.phase == PH_FIRST)
                    begin
                        nxt.low_byte = item.read_data;
                        do_req       = 1'b1;
                        req_addr     = st.pc + 1'b1;
                        req_phase    = PH_SECOND;
                    end
                    else if (st.phase == PH_TARGET)
                    begin
                        nxt.fetched = d;
                        do_done     = 1'b1;
                    end
                    else
                    begin
                        nxt.pc = st.pc + 2'd2;
                        if (st.latched_mode == MODE_REG_A16)
                        begin
                            do_req    = 1'b1;
                            req_addr  = w;
                            req_phase = PH_TARGET;
                        end
                        else if (st.latched_mode >= MODE_A16_REG)
                        begin
                            nxt.dest      = w;
                            nxt.dest_flag = 1'b1;
                            nxt.fetched   = st.held_operand;
                            do_done       = 1'b1;
                        end
                        else
                        begin
                            nxt.fetched = w;
                            do_done     = 1'b1;
                        end
                    end
                end
                default:
                begin
                    do_err = 1'b1;
                end
            endcase
        end

        if (do_err)
        begin
            nxt.phase = PH_IDLE;
            r.kind    = KIND_ERROR;
        end
        else if (do_req)
        begin
            nxt.phase     = req_phase;
            r.kind        = KIND_REQUEST;
            r.bus_address = req_addr;
        end
        else if (do_done)
        begin
            nxt.phase        = PH_IDLE;
            r.kind           = KIND_DONE;
            r.fetched_data   = nxt.fetched;
            r.dest_address   = nxt.dest;
            r.dest_is_memory = nxt.dest_flag;
            r.new_pc         = nxt.pc;
            r.new_hl         = nxt.hl;
            r.hl_written     = (nxt.latched_mode >= MODE_REG_HLI) &&
                               (nxt.latched_mode <= MODE_HLD_REG);
            r.bus_cycles     = nxt.read_count;
        end

        st_next = nxt;
        res     = r;
    end

endmodule

// ----- design/operand_fetch_addressing_unit.sv -----
// Top level of the operand fetch addressing unit: input register, fetch
// state registers and result register around ofau_step. Depends on ofau_pkg.
//
// Usage:
//   The slave channel takes start transactions (tuser = 0) that name an
//   addressing mode with register, HL and PC values, and bus data
//   transactions (tuser = 1) that answer a previous read request.
//   The master channel gives one result per input transaction: a bus read
//   request (tuser = 0), a finished fetch (tuser = 1) or an error (tuser = 2).
//   Each transaction is held in an input register, passes the mode decode
//   and state update combinationally, and lands in the result register.
//   One transaction is taken every cycle while the master side keeps
//   taking results.
//   The fetch state is read and written in the same decode step, so a
//   data transaction may follow its request directly.
//   When the receiver stalls, the result register holds its transaction and
//   the input register holds one more; s_axis_tready drops only when both
//   are full.
//   Reset returns the fetch to idle and clears all fetch state; no result
//   is pending after reset.
module operand_fetch_addressing_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // addr_mode[4:0], reg1_value[20:5], reg2_value[36:21], reg1_is_c[37],
    // reg2_is_c[38], hl_value[54:39], pc_value[70:55], read_data[78:71], zero[79]
    input  logic [79:0] s_axis_tdata,
    // mode[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // bus_address[15:0], fetched_data[31:16], dest_address[47:32],
    // dest_is_memory[48], new_pc[64:49], new_hl[80:65], hl_written[81],
    // bus_cycles[83:82], zero[87:84]
    output logic [87:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]  m_axis_tuser
);
    import ofau_pkg::*;

    logic    in_valid_reg;
    item_t   item_reg;
    item_t   item_next;
    state_t  st_reg;
    state_t  st_next;
    logic    out_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    advance;
    logic    s_fire;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign item_next.is_data    = s_axis_tuser;
    assign item_next.addr_mode  = s_axis_tdata[4:0];
    assign item_next.reg1_value = s_axis_tdata[20:5];
    assign item_next.reg2_value = s_axis_tdata[36:21];
    assign item_next.reg1_is_c  = s_axis_tdata[37];
    assign item_next.reg2_is_c  = s_axis_tdata[38];
    assign item_next.hl_value   = s_axis_tdata[54:39];
    assign item_next.pc_value   = s_axis_tdata[70:55];
    assign item_next.read_data  = s_axis_tdata[78:71];

    ofau_step u_step (
        .item    (item_reg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (s_fire)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (advance)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            item_reg <= item_next;
        if (advance)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tdata  = {4'b0000,
                            res_reg.bus_cycles,
                            res_reg.hl_written,
                            res_reg.new_hl,
                            res_reg.new_pc,
                            res_reg.dest_is_memory,
                            res_reg.dest_address,
                            res_reg.fetched_data,
                            res_reg.bus_address};

endmodule
